[sv/midi_usb_pkg.sv]
`timescale 1ns / 1ps
// shared types and codes for the midi byte to usb event parser
// used by the top level and its port checker, depends on nothing

package midi_usb_pkg;

    typedef logic [7:0] t_midi_byte;
    typedef logic [3:0] t_code_index;
    typedef logic [1:0] t_count;

    // status bytes that get their own handling
    localparam t_midi_byte ST_SYSEX_START = 8'hF0;
    localparam t_midi_byte ST_MTC_QUARTER = 8'hF1;
    localparam t_midi_byte ST_SONG_POS    = 8'hF2;
    localparam t_midi_byte ST_SONG_SEL    = 8'hF3;
    localparam t_midi_byte ST_UNDEF_F4    = 8'hF4;
    localparam t_midi_byte ST_UNDEF_F5    = 8'hF5;
    localparam t_midi_byte ST_TUNE_REQ    = 8'hF6;
    localparam t_midi_byte ST_SYSEX_END   = 8'hF7;
    localparam t_midi_byte ST_REALTIME    = 8'hF8;

    // usb-midi code index numbers
    localparam t_code_index CIN_COMMON_2B  = 4'h2;
    localparam t_code_index CIN_COMMON_3B  = 4'h3;
    localparam t_code_index CIN_SYSEX_CONT = 4'h4;
    localparam t_code_index CIN_SYSEX_END1 = 4'h5;
    localparam t_code_index CIN_SINGLE     = 4'hF;

    localparam t_count LEN_ONE   = 2'd1;
    localparam t_count LEN_TWO   = 2'd2;
    localparam t_count LEN_SYSEX = 2'd3;

endpackage

[sv/midi_byte_to_usb_event_parser_unit.sv]
`timescale 1ns / 1ps
// an accepted byte waits in the input register; its event is written to the output register once the output is free
// throughput: one byte per cycle unless stalled, limited by the single decode stage and the state it updates
// a stalled event holds in the output register; the input register then takes one more byte
// and holds it until the output frees up
// reset (synchronous, active low) clears running status, counts, held bytes and both valids
// file holds the parser top level, depends on midi_usb_pkg

module midi_byte_to_usb_event_parser_unit
    import midi_usb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    output logic [3:0]  o_code_index,
    output logic [7:0]  o_first_byte,
    output logic [7:0]  o_second_byte,
    output logic [7:0]  o_third_byte,
    output logic        o_event_valid,
    input  logic        i_event_ready
);

    // input register
    logic       r_in_valid;
    t_midi_byte r_in_byte;

    // parser state
    t_midi_byte r_running_status, n_running_status;
    t_count     r_byte_count,     n_byte_count;
    t_count     r_message_length, n_message_length;
    t_midi_byte r_held [3];
    t_midi_byte n_held [3];

    // output register
    logic        r_out_valid;
    t_code_index r_code;
    t_midi_byte  r_b1, r_b2, r_b3;

    logic        emit;
    t_code_index n_code;
    t_midi_byte  n_b1, n_b2, n_b3;
    t_count      next_count;

    logic out_free;
    logic proc;

    assign out_free   = !r_out_valid || i_event_ready;
    assign proc       = r_in_valid && out_free;
    assign o_rx_ready = !r_in_valid || out_free;
    assign next_count = r_byte_count + 2'd1;

    always_comb begin
        n_running_status = r_running_status;
        n_byte_count     = r_byte_count;
        n_message_length = r_message_length;
        n_held           = r_held;
        emit             = 1'b0;
        n_code           = CIN_SINGLE;
        n_b1             = r_in_byte;
        n_b2             = '0;
        n_b3             = '0;

        unique case (r_in_byte) inside
            [8'h00:8'h7F]: begin
                if (r_running_status != '0 && r_byte_count != 2'd3) begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_byte_count == 2'(k)) begin
                            n_held[k] = r_in_byte;
                        end
                    end
                    n_byte_count = next_count;
                    if (next_count == r_message_length) begin
                        emit         = 1'b1;
                        n_byte_count = '0;
                        if (r_running_status == ST_SYSEX_START) begin
                            n_code = CIN_SYSEX_CONT;
                            n_b1   = n_held[0];
                            n_b2   = n_held[1];
                            n_b3   = n_held[2];
                        end else begin
                            if (r_running_status < ST_SYSEX_START) begin
                                n_code = r_running_status[7:4];
                            end else if (r_message_length == LEN_ONE) begin
                                n_code = CIN_COMMON_2B;
                            end else if (r_message_length == LEN_TWO) begin
                                n_code = CIN_COMMON_3B;
                            end else begin
                                n_code = CIN_SINGLE;
                            end
                            n_b1 = r_running_status;
                            n_b2 = n_held[0];
                            n_b3 = n_held[1];
                        end
                    end
                end
            end
            [8'h80:8'hBF], [8'hE0:8'hEF]: begin
                n_running_status = r_in_byte;
                n_byte_count     = '0;
                n_message_length = LEN_TWO;
            end
            [8'hC0:8'hDF]: begin
                n_running_status = r_in_byte;
                n_byte_count     = '0;
                n_message_length = LEN_ONE;
            end
            ST_SYSEX_START: begin
                n_running_status = ST_SYSEX_START;
                n_message_length = LEN_SYSEX;
                n_held[0]        = ST_SYSEX_START;
                n_byte_count     = 2'd1;
            end
            ST_MTC_QUARTER, ST_SONG_SEL: begin
                n_running_status = r_in_byte;
                n_byte_count     = '0;
                n_message_length = LEN_ONE;
            end
            ST_SONG_POS: begin
                n_running_status = r_in_byte;
                n_byte_count     = '0;
                n_message_length = LEN_TWO;
            end
            ST_UNDEF_F4, ST_UNDEF_F5: begin
                // dropped
            end
            ST_TUNE_REQ: begin
                n_running_status = '0;
                emit             = 1'b1;
                n_code           = CIN_SYSEX_END1;
            end
            ST_SYSEX_END: begin
                // closes a sysex chunk with the end byte stored at the current count
                if (r_byte_count != 2'd3) begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_byte_count == 2'(k)) begin
                            n_held[k] = r_in_byte;
                        end
                    end
                    emit   = 1'b1;
                    n_code = CIN_SYSEX_CONT + {2'b00, next_count};
                    n_b1   = n_held[0];
                    n_b2   = n_held[1];
                    n_b3   = n_held[2];
                end
                n_running_status = '0;
                n_byte_count     = '0;
                n_message_length = '0;
            end
            [8'hF8:8'hFF]: begin
                emit   = 1'b1;
                n_code = CIN_SINGLE;
            end
            default: begin
                n_running_status = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_running_status <= '0;
            r_byte_count     <= '0;
            r_message_length <= '0;
            r_held[0]        <= '0;
            r_held[1]        <= '0;
            r_held[2]        <= '0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (out_free) begin
                r_out_valid <= proc && emit;
            end
            if (proc) begin
                r_running_status <= n_running_status;
                r_byte_count     <= n_byte_count;
                r_message_length <= n_message_length;
                r_held           <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (proc && emit) begin
            r_code <= n_code;
            r_b1   <= n_b1;
            r_b2   <= n_b2;
            r_b3   <= n_b3;
        end
    end

    assign o_event_valid = r_out_valid;
    assign o_code_index  = r_code;
    assign o_first_byte  = r_b1;
    assign o_second_byte = r_b2;
    assign o_third_byte  = r_b3;

endmodule

[sv/midi_usb_checker.sv]
`timescale 1ns / 1ps
// port-level checker for the parser top level, attached by bind
// depends on midi_usb_pkg and midi_byte_to_usb_event_parser_unit

module midi_usb_checker
    import midi_usb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic [3:0] o_code_index,
    input logic [7:0] o_first_byte,
    input logic [7:0] o_second_byte,
    input logic [7:0] o_third_byte,
    input logic       o_event_valid,
    input logic       i_event_ready
);

    // a stalled event transaction keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event_valid && !i_event_ready |=> o_event_valid && $stable(o_code_index)
            && $stable(o_first_byte) && $stable(o_second_byte) && $stable(o_third_byte))
        else $error("event payload changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_event_valid)
        else $error("event valid after reset");

    // channel events carry their status nibble as the code index
    a_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event_valid && o_code_index >= 4'h8 && o_code_index <= 4'hE
            |-> o_first_byte[7:4] == o_code_index)
        else $error("channel code does not match status");

    // single-byte code only for realtime bytes and realtime bytes only as single
    a_realtime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event_valid |-> ((o_code_index == CIN_SINGLE) == (o_first_byte >= ST_REALTIME)))
        else $error("realtime event mismatch");

endmodule

bind midi_byte_to_usb_event_parser_unit midi_usb_checker u_midi_usb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_code_index  (o_code_index),
    .o_first_byte  (o_first_byte),
    .o_second_byte (o_second_byte),
    .o_third_byte  (o_third_byte),
    .o_event_valid (o_event_valid),
    .i_event_ready (i_event_ready)
);
